// File: design/ecc_pkg.sv
package ecc_pkg;

   // Building size and timing widths
   localparam int FLOOR_COUNT      = 5;
   localparam int FLOOR_W          = $clog2(FLOOR_COUNT + 1);
   localparam int PHASE_W          = 10;
   localparam int CFG_W            = 10;
   localparam int CSR_IDX_W        = 3;
   localparam int IDLE_TIMEOUT     = 300;
   localparam int CAR_CAPACITY_DEF = 10;

   // Register defaults after reset
   localparam logic [CFG_W-1:0] ACCEL_TICKS_RST      = CFG_W'(15);
   localparam logic [CFG_W-1:0] UP_RUN_TICKS_RST     = CFG_W'(51);
   localparam logic [CFG_W-1:0] DOWN_RUN_TICKS_RST   = CFG_W'(61);
   localparam logic [CFG_W-1:0] UP_DECEL_TICKS_RST   = CFG_W'(14);
   localparam logic [CFG_W-1:0] DOWN_DECEL_TICKS_RST = CFG_W'(23);
   localparam logic [CFG_W-1:0] DOOR_TICKS_RST       = CFG_W'(20);
   localparam logic [CFG_W-1:0] PASSENGER_TICKS_RST  = CFG_W'(25);
   localparam logic [CFG_W-1:0] CLOSE_WAIT_TICKS_RST = CFG_W'(40);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_TICKS      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_UP_RUN_TICKS     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_RUN_TICKS   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UP_DECEL_TICKS   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_DECEL_TICKS = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_TICKS       = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_PASSENGER_TICKS  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_WAIT_TICKS = CSR_IDX_W'(7);

   typedef enum logic [3:0] {
      MODE_RUN_DN  = 4'd0,
      MODE_RUN_UP  = 4'd1,
      MODE_ACC_UP  = 4'd2,
      MODE_ACC_DN  = 4'd3,
      MODE_DEC_UP  = 4'd4,
      MODE_DEC_DN  = 4'd5,
      MODE_IDLE    = 4'd6,
      MODE_PARKED  = 4'd7,
      MODE_OPEN    = 4'd8,
      MODE_OPENING = 4'd9,
      MODE_CLOSING = 4'd10,
      MODE_ALIGHT  = 4'd11,
      MODE_BOARD   = 4'd12
   } mode_type;

   typedef struct packed {
      logic [FLOOR_COUNT-1:0] hall_up_press;
      logic [FLOOR_COUNT-1:0] hall_down_press;
      logic                   exit_pending;
      logic                   queue_waiting;
      logic [FLOOR_W-1:0]     head_destination;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]             mode;
      logic [FLOOR_W-1:0]     car_floor;
      logic                   moving_up;
      logic                   alight;
      logic                   board;
      logic                   flush_queue;
      logic [FLOOR_COUNT-1:0] car_calls_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [CFG_W-1:0] accel_ticks;
      logic [CFG_W-1:0] up_run_ticks;
      logic [CFG_W-1:0] down_run_ticks;
      logic [CFG_W-1:0] up_decel_ticks;
      logic [CFG_W-1:0] down_decel_ticks;
      logic [CFG_W-1:0] door_ticks;
      logic [CFG_W-1:0] passenger_ticks;
      logic [CFG_W-1:0] close_wait_ticks;
   } cfg_type;

   // Pending calls as seen this tick (stored bits merged with new presses)
   typedef struct packed {
      logic [FLOOR_COUNT-1:0] hall_up;
      logic [FLOOR_COUNT-1:0] hall_down;
      logic [FLOOR_COUNT-1:0] car;
   } call_view_type;

   // Call updates requested by the sequencer
   typedef struct packed {
      logic [FLOOR_COUNT-1:0] hall_clr;
      logic [FLOOR_COUNT-1:0] car_clr;
      logic [FLOOR_COUNT-1:0] car_set;
   } call_upd_type;

   // Sequencer state after the tick plus strobes
   typedef struct packed {
      mode_type           mode;
      logic [FLOOR_W-1:0] car_floor;
      logic               moving_up;
      logic               alight;
      logic               board;
      logic               flush_queue;
   } seq_out_type;

   // One-hot bit of a floor; floors outside 1..FLOOR_COUNT give no bit
   function automatic logic [FLOOR_COUNT-1:0] floor_bit(input logic [FLOOR_W-1:0] f);
      logic [FLOOR_COUNT-1:0] m;
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         m[i] = (f == FLOOR_W'(i + 1));
      end
      return m;
   endfunction

   function automatic logic [FLOOR_COUNT-1:0] above_mask(input logic [FLOOR_W-1:0] f);
      logic [FLOOR_COUNT-1:0] m;
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         m[i] = (FLOOR_W'(i + 1) > f);
      end
      return m;
   endfunction

   function automatic logic [FLOOR_COUNT-1:0] below_mask(input logic [FLOOR_W-1:0] f);
      logic [FLOOR_COUNT-1:0] m;
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         m[i] = (FLOOR_W'(i + 1) < f);
      end
      return m;
   endfunction

   // Lowest up call first, else highest down call, else zero
   function automatic logic [FLOOR_W-1:0] hall_target(input logic [FLOOR_COUNT-1:0] up,
                                                      input logic [FLOOR_COUNT-1:0] dn);
      logic [FLOOR_W-1:0] up_t;
      logic [FLOOR_W-1:0] dn_t;
      up_t = '0;
      dn_t = '0;
      for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
         if (up[i]) up_t = FLOOR_W'(i + 1);
      end
      for (int i = 0; i < FLOOR_COUNT; i++) begin
         if (dn[i]) dn_t = FLOOR_W'(i + 1);
      end
      return (|up) ? up_t : dn_t;
   endfunction

endpackage

// File: design/ecc_chan_if.sv
interface ecc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/elevator_car_controller_unit.sv
// Path: an accepted transaction waits in the input register, and its result is held in the
//   result register until the receiver takes it; a stall on the result channel holds both.
// Throughput: one transaction per cycle while results are taken; the input register
//   feeds one controller step into the result register; each transaction advances one tick.
// Reset (synchronous, active high): car idle at floor 1 heading down, all calls and
//   load cleared, timing registers back to their defaults, both channel stages empty.
module elevator_car_controller_unit
   import ecc_pkg::*;
#(
   parameter int CAR_CAPACITY = CAR_CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ecc_chan_if.sink             req_ch,
   ecc_chan_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type         cfg_ff;
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff, out_data_in;
   logic            advance;

   call_view_type          calls;
   call_upd_type           upd;
   seq_out_type            seq_res;
   logic [FLOOR_COUNT-1:0] car_calls_next;

   // Step the controller when the result stage can take it
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_ticks      <= ACCEL_TICKS_RST;
         cfg_ff.up_run_ticks     <= UP_RUN_TICKS_RST;
         cfg_ff.down_run_ticks   <= DOWN_RUN_TICKS_RST;
         cfg_ff.up_decel_ticks   <= UP_DECEL_TICKS_RST;
         cfg_ff.down_decel_ticks <= DOWN_DECEL_TICKS_RST;
         cfg_ff.door_ticks       <= DOOR_TICKS_RST;
         cfg_ff.passenger_ticks  <= PASSENGER_TICKS_RST;
         cfg_ff.close_wait_ticks <= CLOSE_WAIT_TICKS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACCEL_TICKS:      cfg_ff.accel_ticks      <= csr_wdata;
            CSR_UP_RUN_TICKS:     cfg_ff.up_run_ticks     <= csr_wdata;
            CSR_DOWN_RUN_TICKS:   cfg_ff.down_run_ticks   <= csr_wdata;
            CSR_UP_DECEL_TICKS:   cfg_ff.up_decel_ticks   <= csr_wdata;
            CSR_DOWN_DECEL_TICKS: cfg_ff.down_decel_ticks <= csr_wdata;
            CSR_DOOR_TICKS:       cfg_ff.door_ticks       <= csr_wdata;
            CSR_PASSENGER_TICKS:  cfg_ff.passenger_ticks  <= csr_wdata;
            CSR_CLOSE_WAIT_TICKS: cfg_ff.close_wait_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input stage: hold a transaction until the step consumes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) in_data_ff <= req_ch.payload;
   end

   ecc_calls u_calls (
      .clock           (clock),
      .reset           (reset),
      .step_en         (advance),
      .hall_up_press   (in_data_ff.hall_up_press),
      .hall_down_press (in_data_ff.hall_down_press),
      .upd             (upd),
      .view            (calls),
      .car_calls_next  (car_calls_next)
   );

   ecc_seq #(
      .CAR_CAPACITY (CAR_CAPACITY)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .step_en          (advance),
      .exit_pending     (in_data_ff.exit_pending),
      .queue_waiting    (in_data_ff.queue_waiting),
      .head_destination (in_data_ff.head_destination),
      .cfg              (cfg_ff),
      .calls            (calls),
      .upd              (upd),
      .res              (seq_res)
   );

   // Result stage
   assign out_data_in.mode          = seq_res.mode;
   assign out_data_in.car_floor     = seq_res.car_floor;
   assign out_data_in.moving_up     = seq_res.moving_up;
   assign out_data_in.alight        = seq_res.alight;
   assign out_data_in.board         = seq_res.board;
   assign out_data_in.flush_queue   = seq_res.flush_queue;
   assign out_data_in.car_calls_out = car_calls_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_data_ff <= out_data_in;
   end

   // At most one passenger event per tick
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0({out_data_ff.alight, out_data_ff.board,
                                 out_data_ff.flush_queue}))
      else $error("more than one passenger strobe in a result");

   // Car floor stays within the building
   a_floor_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.car_floor >= FLOOR_W'(1)) &&
                       (out_data_ff.car_floor <= FLOOR_W'(FLOOR_COUNT)))
      else $error("car floor out of range");

   // A flush leaves the car with the door open or already closing
   a_flush_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.flush_queue) |->
         (out_data_ff.mode == MODE_OPEN) || (out_data_ff.mode == MODE_CLOSING))
      else $error("flush outside door-open modes");

   // A stalled input transaction is neither lost nor overwritten
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_data_ff))
      else $error("input stage lost a pending transaction");

endmodule

// File: design/ecc_calls.sv
module ecc_calls
   import ecc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [FLOOR_COUNT-1:0] hall_up_press,
   input  logic [FLOOR_COUNT-1:0] hall_down_press,
   input  call_upd_type           upd,
   output call_view_type          view,
   output logic [FLOOR_COUNT-1:0] car_calls_next
);

   logic [FLOOR_COUNT-1:0] hall_up_ff, hall_up_in;
   logic [FLOOR_COUNT-1:0] hall_down_ff, hall_down_in;
   logic [FLOOR_COUNT-1:0] car_ff, car_in;

   // Latch new presses ahead of the controller step
   assign view.hall_up   = hall_up_ff | hall_up_press;
   assign view.hall_down = hall_down_ff | hall_down_press;
   assign view.car       = car_ff;

   // Apply served and newly placed calls
   assign hall_up_in   = view.hall_up & ~upd.hall_clr;
   assign hall_down_in = view.hall_down & ~upd.hall_clr;
   assign car_in       = (car_ff & ~upd.car_clr) | upd.car_set;

   assign car_calls_next = car_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hall_up_ff   <= '0;
         hall_down_ff <= '0;
         car_ff       <= '0;
      end else if (step_en) begin
         hall_up_ff   <= hall_up_in;
         hall_down_ff <= hall_down_in;
         car_ff       <= car_in;
      end
   end

endmodule

// File: design/ecc_seq.sv
module ecc_seq
   import ecc_pkg::*;
#(
   parameter int CAR_CAPACITY = CAR_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               exit_pending,
   input  logic               queue_waiting,
   input  logic [FLOOR_W-1:0] head_destination,
   input  cfg_type            cfg,
   input  call_view_type      calls,
   output call_upd_type       upd,
   output seq_out_type        res
);

   localparam int LOAD_W = $clog2(CAR_CAPACITY + 1);

   mode_type           mode_ff, mode_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [FLOOR_W-1:0] floor_ff, floor_in;
   logic               dir_ff, dir_in;
   logic [LOAD_W-1:0]  load_ff, load_in;

   logic [FLOOR_COUNT-1:0] here_bit, up_bit, dn_bit, cu, cd, cud;
   logic [FLOOR_W-1:0]     floor_up, floor_dn, tgt;
   logic                   take, stop_up, stop_dn, tgt_ok, tgt_here, tgt_below;
   logic [PHASE_W-1:0]     ph_inc, reopen_t, open_q, board_p;
   logic                   opening_done, board_pdone, full, board_leave;
   logic                   cw_zero, acc_zero, board_go, board_act, alight_act;
   logic                   timeout, at_bottom, close_done;
   logic                   ac_open, ac_up, ac_dn, take_mode;
   logic                   alight_s, board_s, flush_s;

   // Call views and the floor neighborhood
   assign here_bit = floor_bit(floor_ff);
   assign cu       = calls.car | calls.hall_up;
   assign cd       = calls.car | calls.hall_down;
   assign cud      = cu | calls.hall_down;
   assign take     = dir_ff ? |(calls.hall_up & here_bit) : |(calls.hall_down & here_bit);

   assign floor_up = (floor_ff < FLOOR_W'(FLOOR_COUNT)) ? FLOOR_W'(floor_ff + 1'b1) : floor_ff;
   assign floor_dn = (floor_ff > FLOOR_W'(1)) ? FLOOR_W'(floor_ff - 1'b1) : floor_ff;
   assign up_bit   = floor_bit(floor_up);
   assign dn_bit   = floor_bit(floor_dn);
   assign stop_up  = (|(cu & up_bit)) || !(|(cud & above_mask(floor_up)));
   assign stop_dn  = (|(cd & dn_bit)) || !(|(cud & below_mask(floor_dn)));

   assign tgt       = hall_target(calls.hall_up, calls.hall_down);
   assign tgt_ok    = (tgt != '0);
   assign tgt_here  = (tgt == floor_ff);
   assign tgt_below = (tgt < floor_ff);

   // Phase timing shared by the chained mode steps
   assign ph_inc   = PHASE_W'(phase_ff + 1'b1);
   assign reopen_t = (cfg.door_ticks > phase_ff) ? PHASE_W'(cfg.door_ticks - phase_ff) : '0;
   assign open_q   = (mode_ff == MODE_CLOSING) ? reopen_t :
                     (mode_ff == MODE_OPENING) ? phase_ff : '0;
   assign opening_done = (open_q >= cfg.door_ticks);
   assign board_p      = (mode_ff == MODE_BOARD) ? phase_ff : '0;
   assign board_pdone  = (board_p >= cfg.passenger_ticks);
   assign cw_zero      = (cfg.close_wait_ticks == '0);
   assign acc_zero     = (cfg.accel_ticks == '0);
   assign timeout      = (phase_ff >= PHASE_W'(IDLE_TIMEOUT));
   assign at_bottom    = (floor_ff == FLOOR_W'(1));

   // Passenger handling
   assign full        = (load_ff >= LOAD_W'(CAR_CAPACITY));
   assign board_leave = full || !queue_waiting;
   assign board_go    = (mode_ff == MODE_BOARD) ||
                        ((mode_ff == MODE_ALIGHT) && !exit_pending) ||
                        ((mode_ff == MODE_OPEN) && take);
   assign board_act   = board_go && !board_leave && board_pdone;
   assign alight_act  = (mode_ff == MODE_ALIGHT) && exit_pending &&
                        (phase_ff >= cfg.passenger_ticks);
   assign close_done  = (mode_ff == MODE_CLOSING) && !take && (phase_ff >= cfg.door_ticks);
   assign take_mode   = (mode_ff == MODE_OPENING) || (mode_ff == MODE_ALIGHT) ||
                        (mode_ff == MODE_BOARD) || (mode_ff == MODE_OPEN) ||
                        (mode_ff == MODE_CLOSING) ||
                        (((mode_ff == MODE_IDLE) || (mode_ff == MODE_PARKED)) &&
                         tgt_ok && tgt_here);

   // Decide where the car goes once the door has closed
   always_comb begin
      ac_open = 1'b0;
      ac_up   = 1'b0;
      ac_dn   = 1'b0;
      if (dir_ff) begin
         priority if (|(cu & here_bit))                 ac_open = 1'b1;
         else if (|(cud & above_mask(floor_ff)))        ac_up   = 1'b1;
         else if (|(cd & here_bit))                     ac_open = 1'b1;
         else if (|(cd & below_mask(floor_ff)))         ac_dn   = 1'b1;
         else                                           ac_open = 1'b0;
      end else begin
         priority if (|(cd & here_bit))                 ac_open = 1'b1;
         else if (|(cud & below_mask(floor_ff)))        ac_dn   = 1'b1;
         else if (|(cu & here_bit))                     ac_open = 1'b1;
         else if (|(cu & above_mask(floor_ff)))         ac_up   = 1'b1;
         else                                           ac_open = 1'b0;
      end
   end

   // Next state: mode, phase, floor, direction, load
   always_comb begin
      mode_in  = mode_ff;
      phase_in = ph_inc;
      floor_in = floor_ff;
      dir_in   = dir_ff;
      load_in  = load_ff;
      unique case (mode_ff)
         MODE_RUN_DN: begin
            dir_in = 1'b0;
            if (phase_ff >= cfg.down_run_ticks) begin
               phase_in = '0;
               floor_in = floor_dn;
               if (stop_dn) mode_in = MODE_DEC_DN;
            end
         end
         MODE_RUN_UP: begin
            dir_in = 1'b1;
            if (phase_ff >= cfg.up_run_ticks) begin
               phase_in = '0;
               floor_in = floor_up;
               if (stop_up) mode_in = MODE_DEC_UP;
            end
         end
         MODE_ACC_UP: begin
            if (phase_ff >= cfg.accel_ticks) begin
               mode_in  = MODE_RUN_UP;
               phase_in = '0;
            end
         end
         MODE_ACC_DN: begin
            if (phase_ff >= cfg.accel_ticks) begin
               mode_in  = MODE_RUN_DN;
               phase_in = '0;
            end
         end
         MODE_DEC_UP: begin
            if (phase_ff >= cfg.up_decel_ticks) begin
               mode_in  = MODE_OPENING;
               phase_in = '0;
            end
         end
         MODE_DEC_DN: begin
            if (phase_ff >= cfg.down_decel_ticks) begin
               mode_in  = MODE_OPENING;
               phase_in = '0;
            end
         end
         MODE_IDLE, MODE_PARKED: begin
            if (tgt_ok) begin
               // start serving the hall call within this tick
               if (tgt_here) begin
                  mode_in  = opening_done ? MODE_ALIGHT : MODE_OPENING;
                  phase_in = opening_done ? '0 : PHASE_W'(open_q + 1'b1);
               end else if (tgt_below) begin
                  mode_in  = acc_zero ? MODE_RUN_DN : MODE_ACC_DN;
                  phase_in = acc_zero ? '0 : PHASE_W'(1);
               end else begin
                  mode_in  = acc_zero ? MODE_RUN_UP : MODE_ACC_UP;
                  phase_in = acc_zero ? '0 : PHASE_W'(1);
               end
            end else if (mode_ff == MODE_PARKED) begin
               phase_in = phase_ff;
            end else if (timeout) begin
               mode_in  = at_bottom ? MODE_PARKED : MODE_ACC_DN;
               phase_in = '0;
            end
         end
         MODE_OPENING, MODE_CLOSING: begin
            if (mode_ff == MODE_OPENING || take) begin
               mode_in  = opening_done ? MODE_ALIGHT : MODE_OPENING;
               phase_in = opening_done ? '0 : PHASE_W'(open_q + 1'b1);
            end else if (close_done) begin
               phase_in = '0;
               priority if (ac_open) mode_in = MODE_OPENING;
               else if (ac_up)       mode_in = MODE_ACC_UP;
               else if (ac_dn)       mode_in = MODE_ACC_DN;
               else                  mode_in = MODE_IDLE;
            end
         end
         MODE_OPEN, MODE_ALIGHT, MODE_BOARD: begin
            if (board_go) begin
               // boarding step, possibly falling through to door open
               if (board_leave) begin
                  mode_in  = cw_zero ? MODE_CLOSING : MODE_OPEN;
                  phase_in = cw_zero ? '0 : PHASE_W'(1);
               end else if (board_pdone) begin
                  mode_in  = MODE_BOARD;
                  phase_in = '0;
               end else begin
                  mode_in  = MODE_BOARD;
                  phase_in = PHASE_W'(board_p + 1'b1);
               end
            end else if (mode_ff == MODE_OPEN) begin
               if (phase_ff >= cfg.close_wait_ticks) begin
                  mode_in  = MODE_CLOSING;
                  phase_in = '0;
               end
            end else if (alight_act) begin
               phase_in = '0;
            end
         end
         default: begin
            mode_in  = MODE_IDLE;
            phase_in = '0;
         end
      endcase
      if (alight_act && load_ff != '0) load_in = LOAD_W'(load_ff - 1'b1);
      else if (board_act)              load_in = LOAD_W'(load_ff + 1'b1);
   end

   // Outputs: call updates and strobes
   always_comb begin
      upd.hall_clr = '0;
      upd.car_clr  = '0;
      upd.car_set  = '0;
      alight_s     = alight_act;
      board_s      = board_act;
      flush_s      = board_go && full;
      if (take && take_mode) upd.hall_clr = upd.hall_clr | here_bit;
      if (board_act) begin
         upd.hall_clr = upd.hall_clr | here_bit;
         // out-of-range destinations map to no bit
         if (head_destination != floor_ff) upd.car_set = floor_bit(head_destination);
      end
      unique case (mode_ff)
         MODE_RUN_UP: begin
            if (phase_ff >= cfg.up_run_ticks && stop_up) begin
               upd.hall_clr = upd.hall_clr | up_bit;
               upd.car_clr  = up_bit;
            end
         end
         MODE_RUN_DN: begin
            if (phase_ff >= cfg.down_run_ticks && stop_dn) begin
               upd.hall_clr = upd.hall_clr | dn_bit;
               upd.car_clr  = dn_bit;
            end
         end
         MODE_DEC_UP: begin
            if (phase_ff >= cfg.up_decel_ticks) begin
               upd.hall_clr = upd.hall_clr | here_bit;
               upd.car_clr  = here_bit;
            end
         end
         MODE_DEC_DN: begin
            if (phase_ff >= cfg.down_decel_ticks) begin
               upd.hall_clr = upd.hall_clr | here_bit;
               upd.car_clr  = here_bit;
            end
         end
         MODE_CLOSING: begin
            if (close_done && ac_open) begin
               upd.hall_clr = upd.hall_clr | here_bit;
               upd.car_clr  = here_bit;
            end
         end
         MODE_IDLE: begin
            // idle timeout: park at the lobby or head back to it
            if (!tgt_ok && timeout) begin
               if (at_bottom) upd.car_clr = floor_bit(FLOOR_W'(1));
               else           upd.car_set = floor_bit(FLOOR_W'(1));
            end
         end
         MODE_PARKED: begin
            if (tgt_ok && !tgt_here) upd.car_set = floor_bit(tgt);
         end
         default: begin
         end
      endcase
   end

   assign res.mode        = mode_in;
   assign res.car_floor   = floor_in;
   assign res.moving_up   = dir_in;
   assign res.alight      = alight_s;
   assign res.board       = board_s;
   assign res.flush_queue = flush_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         phase_ff <= '0;
         floor_ff <= FLOOR_W'(1);
         dir_ff   <= 1'b0;
         load_ff  <= '0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         floor_ff <= floor_in;
         dir_ff   <= dir_in;
         load_ff  <= load_in;
      end
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import ecc_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   ecc_chan_if #(.payload_type(req_payload_type)) req_if ();
   ecc_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   elevator_car_controller_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Car state as the testbench sees it
   mode_type               car_mode;
   logic [FLOOR_W-1:0]     car_at;
   logic                   heading_up;
   logic [FLOOR_COUNT-1:0] car_calls;
   logic [FLOOR_COUNT-1:0] hall_up;
   logic [FLOOR_COUNT-1:0] hall_dn;
   logic [PHASE_W-1:0]     phase_ticks;
   logic [3:0]             riders;
   logic [CFG_W-1:0]       timing [8];

   req_payload_type tick_inputs [$];
   rsp_payload_type car_states [$];
   rsp_payload_type want;
   rsp_payload_type got;
   bit              req_taken;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              mismatches;

   function automatic logic [FLOOR_COUNT-1:0] floor_mask(logic [FLOOR_W-1:0] f);
      return FLOOR_COUNT'(1) << (f - 1'b1);
   endfunction

   function automatic bit has_call(logic [FLOOR_COUNT-1:0] m, logic [FLOOR_W-1:0] f);
      return (m & floor_mask(f)) != '0;
   endfunction

   function automatic bit any_above(logic [FLOOR_COUNT-1:0] m, logic [FLOOR_W-1:0] f);
      return (m >> f) != '0;
   endfunction

   function automatic bit any_below(logic [FLOOR_COUNT-1:0] m, logic [FLOOR_W-1:0] f);
      return (m & (floor_mask(f) - 1'b1)) != '0;
   endfunction

   function automatic void clear_halls_here();
      hall_up &= ~floor_mask(car_at);
      hall_dn &= ~floor_mask(car_at);
   endfunction

   function automatic void serve_floor();
      clear_halls_here();
      car_calls &= ~floor_mask(car_at);
   endfunction

   // If this floor has a hall call in the travel direction, drop both hall calls of this floor
   function automatic bit take_hall_call();
      bit hit;
      hit = heading_up ? has_call(hall_up, car_at) : has_call(hall_dn, car_at);
      if (hit) clear_halls_here();
      return hit;
   endfunction

   function automatic void enter_mode(mode_type m);
      car_mode = m;
      phase_ticks = '0;
   endfunction

   // Count one tick; true once the phase has run its limit
   function automatic bit count_phase(logic [PHASE_W-1:0] limit);
      if (phase_ticks < limit) begin
         phase_ticks++;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Lowest up call, else highest down call, else zero
   function automatic logic [FLOOR_W-1:0] hall_pick();
      int i;
      for (i = 1; i <= FLOOR_COUNT; i++) begin
         if (hall_up[i-1]) return FLOOR_W'(i);
      end
      for (i = FLOOR_COUNT; i >= 1; i--) begin
         if (hall_dn[i-1]) return FLOOR_W'(i);
      end
      return '0;
   endfunction

   // Advance the car by one tick and return the state it reports
   function automatic rsp_payload_type advance_car(req_payload_type r);
      rsp_payload_type        o;
      logic [FLOOR_COUNT-1:0] c;
      logic [FLOOR_COUNT-1:0] u;
      logic [FLOOR_COUNT-1:0] d;
      logic [FLOOR_W-1:0]     tgt;
      logic [CFG_W-1:0]       reopen;
      bit                     again;
      int                     pass;
      o = '0;
      hall_up |= r.hall_up_press;
      hall_dn |= r.hall_down_press;
      again = 1'b1;
      for (pass = 0; again && pass < 6; pass++) begin
         again = 1'b0;
         case (car_mode)
            MODE_OPENING: begin
               void'(take_hall_call());
               if (count_phase(timing[CSR_DOOR_TICKS])) enter_mode(MODE_ALIGHT);
            end
            MODE_ALIGHT: begin
               void'(take_hall_call());
               if (r.exit_pending) begin
                  if (count_phase(timing[CSR_PASSENGER_TICKS])) begin
                     phase_ticks = '0;
                     o.alight = 1'b1;
                     if (riders > 0) riders--;
                  end
               end else begin
                  enter_mode(MODE_BOARD);
                  again = 1'b1;
               end
            end
            MODE_BOARD: begin
               void'(take_hall_call());
               if (riders >= CAR_CAPACITY_DEF) begin
                  o.flush_queue = 1'b1;
                  enter_mode(MODE_OPEN);
                  again = 1'b1;
               end else if (!r.queue_waiting) begin
                  enter_mode(MODE_OPEN);
                  again = 1'b1;
               end else if (count_phase(timing[CSR_PASSENGER_TICKS])) begin
                  phase_ticks = '0;
                  o.board = 1'b1;
                  riders++;
                  tgt = r.head_destination;
                  if (tgt >= 1 && tgt <= FLOOR_COUNT && tgt != car_at)
                     car_calls |= floor_mask(tgt);
                  clear_halls_here();
               end
            end
            MODE_OPEN: begin
               if (take_hall_call()) begin
                  enter_mode(MODE_BOARD);
                  again = 1'b1;
               end else if (count_phase(timing[CSR_CLOSE_WAIT_TICKS])) begin
                  enter_mode(MODE_CLOSING);
               end
            end
            MODE_CLOSING: begin
               if (take_hall_call()) begin
                  // reopen from where the door has got to
                  reopen = (timing[CSR_DOOR_TICKS] > phase_ticks) ?
                           timing[CSR_DOOR_TICKS] - phase_ticks : '0;
                  car_mode = MODE_OPENING;
                  phase_ticks = reopen;
                  again = 1'b1;
               end else if (count_phase(timing[CSR_DOOR_TICKS])) begin
                  c = car_calls;
                  u = hall_up;
                  d = hall_dn;
                  if (heading_up) begin
                     if (has_call(c | u, car_at)) begin
                        serve_floor();
                        enter_mode(MODE_OPENING);
                     end else if (any_above(c | u | d, car_at)) begin
                        enter_mode(MODE_ACC_UP);
                     end else if (has_call(c | d, car_at)) begin
                        serve_floor();
                        enter_mode(MODE_OPENING);
                     end else if (any_below(c | d, car_at)) begin
                        enter_mode(MODE_ACC_DN);
                     end else begin
                        enter_mode(MODE_IDLE);
                     end
                  end else begin
                     if (has_call(c | d, car_at)) begin
                        serve_floor();
                        enter_mode(MODE_OPENING);
                     end else if (any_below(c | u | d, car_at)) begin
                        enter_mode(MODE_ACC_DN);
                     end else if (has_call(c | u, car_at)) begin
                        serve_floor();
                        enter_mode(MODE_OPENING);
                     end else if (any_above(c | u, car_at)) begin
                        enter_mode(MODE_ACC_UP);
                     end else begin
                        enter_mode(MODE_IDLE);
                     end
                  end
               end
            end
            MODE_ACC_UP: begin
               if (count_phase(timing[CSR_ACCEL_TICKS])) enter_mode(MODE_RUN_UP);
            end
            MODE_ACC_DN: begin
               if (count_phase(timing[CSR_ACCEL_TICKS])) enter_mode(MODE_RUN_DN);
            end
            MODE_RUN_UP: begin
               heading_up = 1'b1;
               if (count_phase(timing[CSR_UP_RUN_TICKS])) begin
                  phase_ticks = '0;
                  if (car_at < FLOOR_COUNT) car_at++;
                  if (has_call(car_calls | hall_up, car_at) ||
                      !any_above(car_calls | hall_up | hall_dn, car_at)) begin
                     serve_floor();
                     enter_mode(MODE_DEC_UP);
                  end
               end
            end
            MODE_RUN_DN: begin
               heading_up = 1'b0;
               if (count_phase(timing[CSR_DOWN_RUN_TICKS])) begin
                  phase_ticks = '0;
                  if (car_at > 1) car_at--;
                  if (has_call(car_calls | hall_dn, car_at) ||
                      !any_below(car_calls | hall_up | hall_dn, car_at)) begin
                     serve_floor();
                     enter_mode(MODE_DEC_DN);
                  end
               end
            end
            MODE_DEC_UP: begin
               if (count_phase(timing[CSR_UP_DECEL_TICKS])) begin
                  serve_floor();
                  enter_mode(MODE_OPENING);
               end
            end
            MODE_DEC_DN: begin
               if (count_phase(timing[CSR_DOWN_DECEL_TICKS])) begin
                  serve_floor();
                  enter_mode(MODE_OPENING);
               end
            end
            MODE_IDLE: begin
               tgt = hall_pick();
               if (tgt != 0) begin
                  if (tgt == car_at) enter_mode(MODE_OPENING);
                  else if (tgt < car_at) enter_mode(MODE_ACC_DN);
                  else enter_mode(MODE_ACC_UP);
                  again = 1'b1;
               end else if (count_phase(PHASE_W'(IDLE_TIMEOUT))) begin
                  // park at the lobby, or head back to it
                  if (car_at == 1) begin
                     car_calls[0] = 1'b0;
                     enter_mode(MODE_PARKED);
                  end else begin
                     car_calls[0] = 1'b1;
                     enter_mode(MODE_ACC_DN);
                  end
               end
            end
            MODE_PARKED: begin
               tgt = hall_pick();
               if (tgt != 0) begin
                  if (tgt == car_at) begin
                     enter_mode(MODE_OPENING);
                  end else begin
                     car_calls |= floor_mask(tgt);
                     enter_mode(tgt > car_at ? MODE_ACC_UP : MODE_ACC_DN);
                  end
                  again = 1'b1;
               end
            end
            default: enter_mode(MODE_IDLE);
         endcase
      end
      o.mode = car_mode;
      o.car_floor = car_at;
      o.moving_up = heading_up;
      o.car_calls_out = car_calls;
      return o;
   endfunction

   task automatic report_field(string field, logic [9:0] want_v, logic [9:0] got_v);
      $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
      mismatches++;
   endtask

   task automatic write_timing(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      timing[idx] = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic load_timings(int accel, int up_run, int dn_run, int up_dec, int dn_dec,
                               int door, int rider, int close_wait);
      write_timing(CSR_ACCEL_TICKS, CFG_W'(accel));
      write_timing(CSR_UP_RUN_TICKS, CFG_W'(up_run));
      write_timing(CSR_DOWN_RUN_TICKS, CFG_W'(dn_run));
      write_timing(CSR_UP_DECEL_TICKS, CFG_W'(up_dec));
      write_timing(CSR_DOWN_DECEL_TICKS, CFG_W'(dn_dec));
      write_timing(CSR_DOOR_TICKS, CFG_W'(door));
      write_timing(CSR_PASSENGER_TICKS, CFG_W'(rider));
      write_timing(CSR_CLOSE_WAIT_TICKS, CFG_W'(close_wait));
   endtask

   task automatic queue_tick(logic [FLOOR_COUNT-1:0] up, logic [FLOOR_COUNT-1:0] dn,
                             logic rider_exit, logic waiting, logic [FLOOR_W-1:0] dest);
      req_payload_type r;
      r.hall_up_press = up;
      r.hall_down_press = dn;
      r.exit_pending = rider_exit;
      r.queue_waiting = waiting;
      r.head_destination = dest;
      tick_inputs.push_back(r);
   endtask

   // Ticks in bursts of a fixed rider mix, so loads build up and drain
   task automatic queue_traffic(int count);
      int                     k;
      int                     burst;
      int                     exit_pct;
      int                     wait_pct;
      int                     press_pct;
      logic [FLOOR_COUNT-1:0] up_bits;
      logic [FLOOR_COUNT-1:0] dn_bits;
      logic [FLOOR_W-1:0]     dest;
      burst = 0;
      exit_pct = 0;
      wait_pct = 0;
      press_pct = 0;
      for (k = 0; k < count; k++) begin
         if (burst == 0) begin
            burst = $urandom_range(60, 10);
            exit_pct = 10 + 40 * $urandom_range(2);
            wait_pct = 10 + 42 * $urandom_range(2);
            press_pct = $urandom_range(1) ? 3 : 20;
         end
         burst--;
         up_bits = '0;
         dn_bits = '0;
         if ($urandom_range(99) < press_pct)
            up_bits = $urandom_range(2) ? FLOOR_COUNT'(1) << $urandom_range(FLOOR_COUNT - 1)
                                        : FLOOR_COUNT'($urandom);
         if ($urandom_range(99) < press_pct)
            dn_bits = $urandom_range(2) ? FLOOR_COUNT'(1) << $urandom_range(FLOOR_COUNT - 1)
                                        : FLOOR_COUNT'($urandom);
         dest = $urandom_range(7) ? FLOOR_W'($urandom_range(FLOOR_COUNT, 1))
                                  : FLOOR_W'($urandom);
         queue_tick(up_bits, dn_bits, $urandom_range(99) < exit_pct,
                    $urandom_range(99) < wait_pct, dest);
      end
   endtask

   // No new presses, long enough for the idle timeout to fire
   task automatic queue_quiet(int count);
      int k;
      for (k = 0; k < count; k++)
         queue_tick('0, '0, $urandom_range(9) == 0, $urandom_range(9) == 0,
                    FLOOR_W'($urandom_range(FLOOR_COUNT, 1)));
   endtask

   // Hold off until every tick is sent and every car state has come back
   task automatic settle();
      while (tick_inputs.size() != 0 || req_if.valid || car_states.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Drive the next tick once the current one is taken
   always @(negedge clock) begin
      if (!req_if.valid || req_taken) begin
         if (tick_inputs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.payload <= tick_inputs.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Predict on each accepted tick, check each returned car state
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            car_states.push_back(advance_car(req_if.payload));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (car_states.size() == 0) begin
               $display("%0t: car state %h with nothing expected", $time, got);
               mismatches++;
            end else begin
               want = car_states.pop_front();
               if (got.mode !== want.mode)
                  report_field("mode", 10'(want.mode), 10'(got.mode));
               if (got.car_floor !== want.car_floor)
                  report_field("car_floor", 10'(want.car_floor), 10'(got.car_floor));
               if (got.moving_up !== want.moving_up)
                  report_field("moving_up", 10'(want.moving_up), 10'(got.moving_up));
               if (got.alight !== want.alight)
                  report_field("alight", 10'(want.alight), 10'(got.alight));
               if (got.board !== want.board)
                  report_field("board", 10'(want.board), 10'(got.board));
               if (got.flush_queue !== want.flush_queue)
                  report_field("flush_queue", 10'(want.flush_queue), 10'(got.flush_queue));
               if (got.car_calls_out !== want.car_calls_out)
                  report_field("car_calls_out", 10'(want.car_calls_out),
                               10'(got.car_calls_out));
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      car_mode = MODE_IDLE;
      car_at = FLOOR_W'(1);
      heading_up = 1'b0;
      car_calls = '0;
      hall_up = '0;
      hall_dn = '0;
      phase_ticks = '0;
      riders = '0;
      timing[CSR_ACCEL_TICKS] = ACCEL_TICKS_RST;
      timing[CSR_UP_RUN_TICKS] = UP_RUN_TICKS_RST;
      timing[CSR_DOWN_RUN_TICKS] = DOWN_RUN_TICKS_RST;
      timing[CSR_UP_DECEL_TICKS] = UP_DECEL_TICKS_RST;
      timing[CSR_DOWN_DECEL_TICKS] = DOWN_DECEL_TICKS_RST;
      timing[CSR_DOOR_TICKS] = DOOR_TICKS_RST;
      timing[CSR_PASSENGER_TICKS] = PASSENGER_TICKS_RST;
      timing[CSR_CLOSE_WAIT_TICKS] = CLOSE_WAIT_TICKS_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // All timings set to 1, no idling; directed ticks first
      load_timings(1, 1, 1, 1, 1, 1, 1, 1);
      queue_tick('0, '0, 1'b0, 1'b0, FLOOR_W'(1));
      queue_tick(5'b00001, '0, 1'b0, 1'b0, FLOOR_W'(1));
      queue_tick('0, '0, 1'b1, 1'b0, FLOOR_W'(1));
      queue_tick('0, '0, 1'b1, 1'b0, FLOOR_W'(1));
      queue_tick('0, '0, 1'b1, 1'b1, FLOOR_W'(1));
      queue_tick('0, '0, 1'b1, 1'b1, FLOOR_W'(1));
      queue_tick('0, '0, 1'b0, 1'b1, FLOOR_W'(1));
      queue_tick('0, '0, 1'b0, 1'b1, FLOOR_W'(1));
      queue_tick('0, '0, 1'b0, 1'b1, FLOOR_W'(0));
      queue_tick('0, '0, 1'b0, 1'b1, FLOOR_W'(0));
      queue_tick('0, '0, 1'b0, 1'b1, FLOOR_W'(7));
      queue_tick('0, '0, 1'b0, 1'b1, FLOOR_W'(6));
      queue_tick('0, '0, 1'b0, 1'b1, FLOOR_W'(5));
      queue_tick('0, '0, 1'b0, 1'b1, FLOOR_W'(3));
      queue_tick('0, '0, 1'b0, 1'b0, FLOOR_W'(2));
      queue_tick(5'b11111, 5'b11111, 1'b0, 1'b0, FLOOR_W'(4));
      queue_tick('0, 5'b10000, 1'b1, 1'b1, FLOOR_W'(5));
      queue_tick('0, '0, 1'b0, 1'b0, FLOOR_W'(1));
      queue_tick(5'b00001, '0, 1'b0, 1'b0, FLOOR_W'(1));
      queue_tick('0, '0, 1'b0, 1'b0, FLOOR_W'(1));
      queue_tick('0, 5'b00001, 1'b0, 1'b1, FLOOR_W'(2));
      queue_traffic(300);
      queue_quiet(350);
      settle();

      // Small timings, sender mostly idle
      load_timings($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(4, 1),
                   $urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(4, 1),
                   $urandom_range(4, 1), $urandom_range(4, 1));
      send_idle_pct = 82;
      queue_traffic(200);
      settle();

      // Receiver mostly stalled
      load_timings($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1),
                   $urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1),
                   $urandom_range(6, 1), $urandom_range(6, 1));
      send_idle_pct = 0;
      recv_stall_pct = 82;
      queue_traffic(150);
      settle();

      // Both sides pause now and then
      load_timings($urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1),
                   $urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1),
                   1, $urandom_range(3, 1));
      send_idle_pct = 29;
      recv_stall_pct = 29;
      queue_traffic(200);
      settle();

      // Longest timings
      load_timings(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_traffic(100);
      settle();

      // Back to the power-up timings
      load_timings(int'(ACCEL_TICKS_RST), int'(UP_RUN_TICKS_RST), int'(DOWN_RUN_TICKS_RST),
                   int'(UP_DECEL_TICKS_RST), int'(DOWN_DECEL_TICKS_RST),
                   int'(DOOR_TICKS_RST), int'(PASSENGER_TICKS_RST),
                   int'(CLOSE_WAIT_TICKS_RST));
      send_idle_pct = 29;
      recv_stall_pct = 29;
      queue_traffic(200);
      settle();

      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
